// ===== rtl/rgbtpg_pkg.sv =====
// Shared types, constants and helpers of the RGB565 test pattern generator.
package rgbtpg_pkg;

   localparam int COORD_W     = 9;
   localparam int MODE_W      = 3;
   localparam int COLOR_W     = 16;
   localparam int QUOT_W      = 6;
   localparam int STEP_W      = $clog2(QUOT_W);
   localparam int REM_W       = 15;
   localparam int BAR_SUM_W   = 12;
   localparam int BAR_COUNT   = 6;
   localparam int QUEUE_DEPTH = 2;

   localparam int REQ_DATA_W  = 8;
   localparam int RSP_DATA_W  = 40;
   localparam int CSR_ADDR_W  = 4;
   localparam int CSR_DATA_W  = 32;
   localparam int REG_IDX_W   = 2;

   localparam int DEFAULT_MAX_DIMENSION = 320;

   // pattern modes
   localparam logic [MODE_W-1:0] MODE_RED      = 3'd0;
   localparam logic [MODE_W-1:0] MODE_GREEN    = 3'd1;
   localparam logic [MODE_W-1:0] MODE_BLUE     = 3'd2;
   localparam logic [MODE_W-1:0] MODE_GRADIENT = 3'd3;
   localparam logic [MODE_W-1:0] MODE_BARS     = 3'd4;

   // register indexes
   localparam logic [REG_IDX_W-1:0] REG_MODE   = 2'd0;
   localparam logic [REG_IDX_W-1:0] REG_WIDTH  = 2'd1;
   localparam logic [REG_IDX_W-1:0] REG_HEIGHT = 2'd2;

   localparam logic [MODE_W-1:0]  RESET_MODE   = MODE_BARS;
   localparam logic [COORD_W-1:0] RESET_WIDTH  = 9'd240;
   localparam logic [COORD_W-1:0] RESET_HEIGHT = 9'd280;

   localparam logic [COLOR_W-1:0] COLOR_BLACK   = 16'h0000;
   localparam logic [COLOR_W-1:0] COLOR_RED     = 16'hF800;
   localparam logic [COLOR_W-1:0] COLOR_GREEN   = 16'h07E0;
   localparam logic [COLOR_W-1:0] COLOR_BLUE    = 16'h001F;
   localparam logic [COLOR_W-1:0] COLOR_YELLOW  = 16'hFFE0;
   localparam logic [COLOR_W-1:0] COLOR_MAGENTA = 16'hF81F;
   localparam logic [COLOR_W-1:0] COLOR_CYAN    = 16'h07FF;
   localparam logic [COLOR_W-1:0] COLOR_WHITE   = 16'hFFFF;

   localparam logic [COLOR_W-1:0] BAR_COLORS [BAR_COUNT] = '{
      COLOR_RED, COLOR_GREEN, COLOR_BLUE, COLOR_YELLOW, COLOR_MAGENTA, COLOR_CYAN
   };

   typedef struct packed {
      logic [MODE_W-1:0]  mode;
      logic [COORD_W-1:0] width;
      logic [COORD_W-1:0] height;
   } cfg_type;

   typedef struct packed {
      logic [COORD_W-1:0] column;
      logic [COORD_W-1:0] row;
      logic               line_end;
      logic               frame_end;
   } pixel_pos_type;

   // zero reads as one, anything above the cap reads as the cap
   function automatic logic [COORD_W-1:0] clamp_dim(input logic [COORD_W-1:0] value,
                                                    input logic [COORD_W-1:0] cap);
      logic [COORD_W-1:0] result;
      result = value;
      if (value == '0) begin
         result = COORD_W'(1);
      end else if (value > cap) begin
         result = cap;
      end
      return result;
   endfunction

endpackage

// ===== rtl/rgbtpg_front.sv =====
// Front end: accepts tick beats, steps the raster counters and tags each pixel position.
module rgbtpg_front (
   input  logic                    clock,
   input  logic                    reset,
   input  rgbtpg_pkg::cfg_type     cfg,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   input  logic                    restart_frame,
   input  logic                    queue_full,
   output logic                    push,
   output rgbtpg_pkg::pixel_pos_type push_data
);
   import rgbtpg_pkg::*;

   logic [COORD_W-1:0] column_ff, column_in;
   logic [COORD_W-1:0] row_ff, row_in;
   logic [COORD_W-1:0] x;
   logic [COORD_W:0]   y_wide;
   logic [COORD_W-1:0] y;
   logic               line_end;
   logic               frame_end;

   assign req_tready = !queue_full;
   assign push       = req_tvalid && !queue_full;

   always_comb begin
      x      = column_ff;
      y_wide = {1'b0, row_ff};
      if (restart_frame) begin
         x      = '0;
         y_wide = '0;
      end else begin
         // counter past a shrunken line: start the next row
         if (column_ff >= cfg.width) begin
            x      = '0;
            y_wide = {1'b0, row_ff} + (COORD_W+1)'(1);
         end
         if (y_wide >= {1'b0, cfg.height}) begin
            y_wide = '0;
         end
      end
      y         = y_wide[COORD_W-1:0];
      line_end  = (x == cfg.width - COORD_W'(1));
      frame_end = line_end && (y == cfg.height - COORD_W'(1));
   end

   always_comb begin
      column_in = column_ff;
      row_in    = row_ff;
      if (push) begin
         if (line_end) begin
            column_in = '0;
            row_in    = frame_end ? '0 : y + COORD_W'(1);
         end else begin
            column_in = x + COORD_W'(1);
            row_in    = y;
         end
      end
   end

   assign push_data.column    = x;
   assign push_data.row       = y;
   assign push_data.line_end  = line_end;
   assign push_data.frame_end = frame_end;

   always_ff @(posedge clock) begin
      if (reset) begin
         column_ff <= '0;
         row_ff    <= '0;
      end else begin
         column_ff <= column_in;
         row_ff    <= row_in;
      end
   end

endmodule

// ===== rtl/rgbtpg_fifo.sv =====
// Short queue of pixel positions between the front end and the color engine.
module rgbtpg_fifo (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  rgbtpg_pkg::pixel_pos_type push_data,
   output logic                      full,
   input  logic                      pop,
   output rgbtpg_pkg::pixel_pos_type pop_data,
   output logic                      empty
);
   import rgbtpg_pkg::*;

   localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   pixel_pos_type    entry_ff [QUEUE_DEPTH];
   logic [IDX_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [IDX_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign full     = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign empty    = (count_ff == '0);
   assign pop_data = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + IDX_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + IDX_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ===== rtl/rgbtpg_back.sv =====
// Color engine: turns queued pixel positions into RGB565 result beats.
module rgbtpg_back (
   input  logic                                  clock,
   input  logic                                  reset,
   input  rgbtpg_pkg::cfg_type                   cfg,
   input  logic                                  queue_empty,
   input  rgbtpg_pkg::pixel_pos_type             queue_data,
   output logic                                  pop,
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   output logic [rgbtpg_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   output logic                                  rsp_tuser,
   output logic                                  rsp_tlast
);
   import rgbtpg_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_DIVIDE = 3'b010,
      ST_DONE   = 3'b100
   } back_state_type;

   back_state_type      state_ff, state_in;
   pixel_pos_type       pos_ff, pos_in;
   logic [REM_W-1:0]    rem_x_ff, rem_x_in;
   logic [REM_W-1:0]    rem_y_ff, rem_y_in;
   logic [QUOT_W-1:0]   quot_x_ff, quot_x_in;
   logic [QUOT_W-1:0]   quot_y_ff, quot_y_in;
   logic [STEP_W-1:0]   step_ff, step_in;
   logic                out_valid_ff, out_valid_in;
   logic [RSP_DATA_W-1:0] out_data_ff, out_data_in;
   logic                out_user_ff, out_user_in;
   logic                out_last_ff, out_last_in;

   logic                slot_free;
   logic                load_out;
   logic [REM_W-1:0]    div_x;
   logic [REM_W-1:0]    div_y;
   logic [REM_W-1:0]    head_col;
   logic [REM_W-1:0]    head_row;
   logic [BAR_SUM_W-1:0] six_x_next;
   logic [BAR_COUNT-2:0] bar_hit;
   logic [COLOR_W-1:0]  bar_color;
   logic [COLOR_W-1:0]  color;
   logic [COORD_W:0]    diag_sum;

   assign slot_free = !out_valid_ff || rsp_tready;
   assign load_out  = (state_ff == ST_DONE) && slot_free;

   always_comb begin
      case (state_ff)
         ST_IDLE: pop = !queue_empty;
         ST_DONE: pop = slot_free && !queue_empty;
         default: pop = 1'b0;
      endcase
   end

   // dividends x*31 and y*63 by shift and subtract
   assign head_col = REM_W'(queue_data.column);
   assign head_row = REM_W'(queue_data.row);
   assign div_x    = REM_W'(cfg.width) << step_ff;
   assign div_y    = REM_W'(cfg.height) << step_ff;

   always_comb begin
      state_in  = state_ff;
      pos_in    = pos_ff;
      rem_x_in  = rem_x_ff;
      rem_y_in  = rem_y_ff;
      quot_x_in = quot_x_ff;
      quot_y_in = quot_y_ff;
      step_in   = step_ff;
      case (state_ff)
         ST_IDLE: begin
            state_in = ST_IDLE;
         end
         ST_DIVIDE: begin
            // one restoring quotient bit per cycle, most significant first
            if (rem_x_ff >= div_x) begin
               rem_x_in  = rem_x_ff - div_x;
               quot_x_in = quot_x_ff | (QUOT_W'(1) << step_ff);
            end
            if (rem_y_ff >= div_y) begin
               rem_y_in  = rem_y_ff - div_y;
               quot_y_in = quot_y_ff | (QUOT_W'(1) << step_ff);
            end
            if (step_ff == '0) begin
               state_in = ST_DONE;
            end else begin
               step_in = step_ff - STEP_W'(1);
            end
         end
         ST_DONE: begin
            if (slot_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      if (pop) begin
         pos_in    = queue_data;
         rem_x_in  = (head_col << 5) - head_col;
         rem_y_in  = (head_row << 6) - head_row;
         quot_x_in = '0;
         quot_y_in = '0;
         step_in   = STEP_W'(QUOT_W - 1);
         state_in  = (cfg.mode == MODE_GRADIENT) ? ST_DIVIDE : ST_DONE;
      end
   end

   // bar k holds x < floor(w*(k+1)/6), i.e. 6x+6 <= w*(k+1)
   assign six_x_next = (BAR_SUM_W'(pos_ff.column) << 2) + (BAR_SUM_W'(pos_ff.column) << 1)
                       + BAR_SUM_W'(BAR_COUNT);

   always_comb begin
      for (int k = 0; k < BAR_COUNT - 1; k++) begin
         bar_hit[k] = six_x_next <= BAR_SUM_W'(cfg.width) * BAR_SUM_W'(k + 1);
      end
      bar_color = BAR_COLORS[BAR_COUNT-1];
      for (int k = BAR_COUNT - 2; k >= 0; k--) begin
         if (bar_hit[k]) begin
            bar_color = BAR_COLORS[k];
         end
      end
      diag_sum = {1'b0, pos_ff.column} + {1'b0, pos_ff.row};
      if (pos_ff.column == '0 || pos_ff.row == '0 ||
          pos_ff.column == cfg.width - COORD_W'(1) ||
          pos_ff.row == cfg.height - COORD_W'(1)) begin
         bar_color = COLOR_WHITE;
      end
      if (pos_ff.column == pos_ff.row ||
          diag_sum == {1'b0, cfg.width} - (COORD_W+1)'(1)) begin
         bar_color = COLOR_WHITE;
      end
   end

   always_comb begin
      case (cfg.mode)
         MODE_RED:      color = COLOR_RED;
         MODE_GREEN:    color = COLOR_GREEN;
         MODE_BLUE:     color = COLOR_BLUE;
         MODE_GRADIENT: color = {quot_x_ff[4:0], quot_y_ff[5:0], 5'b0};
         MODE_BARS:     color = bar_color;
         default:       color = COLOR_BLACK;
      endcase
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      out_data_in  = out_data_ff;
      out_user_in  = out_user_ff;
      out_last_in  = out_last_ff;
      if (load_out) begin
         out_valid_in = 1'b1;
         out_data_in  = RSP_DATA_W'({pos_ff.row, pos_ff.column, color});
         out_user_in  = pos_ff.line_end;
         out_last_in  = pos_ff.frame_end;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tuser  = out_user_ff;
   assign rsp_tlast  = out_last_ff;

   always_ff @(posedge clock) begin
      pos_ff      <= pos_in;
      rem_x_ff    <= rem_x_in;
      rem_y_ff    <= rem_y_in;
      quot_x_ff   <= quot_x_in;
      quot_y_ff   <= quot_y_in;
      step_ff     <= step_in;
      out_data_ff <= out_data_in;
      out_user_ff <= out_user_in;
      out_last_ff <= out_last_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

endmodule

// ===== rtl/rgb565_test_pattern_generator.sv =====
// Top level of the RGB565 test pattern generator: register file, front end, queue, color engine.
//
// Each beat on the req_ channel is one pixel tick; the block answers it with exactly one
// rsp_ beat carrying the RGB565 color, the column and row of that pixel, a line-end flag
// (tuser) and a frame-end flag (tlast). Bit 0 of req_tdata forces the pixel to the origin.
// The front end takes one tick per cycle while its two-entry queue has room; the color
// engine behind it finishes solid, bar and unused modes at one pixel per cycle while its
// output register is free; gradient mode handles one pixel at a time in the quotient unit
// (a load, then six restoring steps computing x*31/width and y*63/height side by side). A
// result waits in the output register until taken; the engine holds the next until then. Width
// and height read as 1 when written as zero and are capped at MAX_DIMENSION; mode, width
// and height lie at byte addresses 0, 4 and 8 and may only be changed while no tick is
// in flight. A counter left beyond a shrunken frame wraps to the next row or to row 0.
module rgb565_test_pattern_generator #(
   parameter int MAX_DIMENSION = rgbtpg_pkg::DEFAULT_MAX_DIMENSION
) (
   input  logic                                clock,
   input  logic                                reset,
   // tick channel
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [rgbtpg_pkg::REQ_DATA_W-1:0]   req_tdata,  // [0] restart_frame, [7:1] zero
   // pixel channel
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [rgbtpg_pkg::RSP_DATA_W-1:0]   rsp_tdata,  // [15:0] pixel_color,
                                                           // [24:16] column, [33:25] row,
                                                           // [39:34] zero
   output logic                                rsp_tuser,  // line_end
   output logic                                rsp_tlast,  // frame_end
   // register port
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [rgbtpg_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [rgbtpg_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [rgbtpg_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                                csr_pready
);
   import rgbtpg_pkg::*;

   // largest dimension a 9-bit register can ask for, limited by the parameter
   localparam int DIM_LIMIT = (1 << COORD_W) - 1;
   localparam logic [COORD_W-1:0] DIM_CAP =
      COORD_W'((MAX_DIMENSION > DIM_LIMIT) ? DIM_LIMIT : MAX_DIMENSION);

   logic [MODE_W-1:0]    mode_ff, mode_in;
   logic [COORD_W-1:0]   width_ff, width_in;
   logic [COORD_W-1:0]   height_ff, height_in;
   logic                 csr_write;
   logic [REG_IDX_W-1:0] reg_idx;
   cfg_type              cfg;

   logic                 push;
   pixel_pos_type        push_data;
   logic                 queue_full;
   logic                 queue_empty;
   logic                 pop;
   pixel_pos_type        pop_data;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign reg_idx    = csr_paddr[CSR_ADDR_W-1:2];

   // write: take the register's own width from the data, drop the rest
   always_comb begin
      mode_in   = mode_ff;
      width_in  = width_ff;
      height_in = height_ff;
      if (csr_write) begin
         case (reg_idx)
            REG_MODE:   mode_in   = csr_pwdata[MODE_W-1:0];
            REG_WIDTH:  width_in  = csr_pwdata[COORD_W-1:0];
            REG_HEIGHT: height_in = csr_pwdata[COORD_W-1:0];
            default:    mode_in   = mode_ff;
         endcase
      end
   end

   // read: raw register contents, unclamped
   always_comb begin
      case (reg_idx)
         REG_MODE:   csr_prdata = CSR_DATA_W'(mode_ff);
         REG_WIDTH:  csr_prdata = CSR_DATA_W'(width_ff);
         REG_HEIGHT: csr_prdata = CSR_DATA_W'(height_ff);
         default:    csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= RESET_MODE;
         width_ff  <= RESET_WIDTH;
         height_ff <= RESET_HEIGHT;
      end else begin
         mode_ff   <= mode_in;
         width_ff  <= width_in;
         height_ff <= height_in;
      end
   end

   // clamped view used by both halves
   assign cfg.mode   = mode_ff;
   assign cfg.width  = clamp_dim(width_ff, DIM_CAP);
   assign cfg.height = clamp_dim(height_ff, DIM_CAP);

   rgbtpg_front u_front (
      .clock         (clock),
      .reset         (reset),
      .cfg           (cfg),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .restart_frame (req_tdata[0]),
      .queue_full    (queue_full),
      .push          (push),
      .push_data     (push_data)
   );

   rgbtpg_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .full      (queue_full),
      .pop       (pop),
      .pop_data  (pop_data),
      .empty     (queue_empty)
   );

   rgbtpg_back u_back (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg),
      .queue_empty (queue_empty),
      .queue_data  (pop_data),
      .pop         (pop),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast)
   );

endmodule

// ===== rtl/rgbtpg_checker.sv =====
// Port-level checks of the RGB565 test pattern generator, bound to its top level.
module rgbtpg_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              rsp_tvalid,
   input logic                              rsp_tready,
   input logic [rgbtpg_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input logic                              rsp_tuser,
   input logic                              rsp_tlast
);
   import rgbtpg_pkg::*;

   logic rsp_beat;
   logic prev_line_end_ff, prev_line_end_in;
   logic prev_frame_end_ff, prev_frame_end_in;

   assign rsp_beat = rsp_tvalid && rsp_tready;

   always_comb begin
      prev_line_end_in  = prev_line_end_ff;
      prev_frame_end_in = prev_frame_end_ff;
      if (rsp_beat) begin
         prev_line_end_in  = rsp_tuser;
         prev_frame_end_in = rsp_tlast;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_line_end_ff  <= 1'b0;
         prev_frame_end_ff <= 1'b0;
      end else begin
         prev_line_end_ff  <= prev_line_end_in;
         prev_frame_end_ff <= prev_frame_end_in;
      end
   end

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=>
         rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("pixel beat changed while stalled");

   a_frame_end_on_line_end: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast |-> rsp_tuser)
      else $error("frame end without line end");

   a_line_wraps: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && prev_line_end_ff |-> rsp_tdata[24:16] == '0)
      else $error("pixel after line end not at column 0");

   a_frame_wraps: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && prev_frame_end_ff |-> rsp_tdata[33:25] == '0)
      else $error("pixel after frame end not at row 0");

   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("pixel beat valid right after reset");

endmodule

bind rgb565_test_pattern_generator rgbtpg_checker u_rgbtpg_checker (.*);
